>>> hdl/hap_pkg.sv
// Shared types and constants for the Hammer-Aitoff projection pipeline.
// No dependencies; every other file in hdl/ imports this package.
package hap_pkg;

    // Default number of fraction bits on the degree fields
    localparam int FRAC_BITS_DEF = 8;

    // Field widths of the stream beats
    localparam int LON_W = 17;
    localparam int LAT_W = 16;
    localparam int X_W   = 17;
    localparam int Y_W   = 16;
    localparam int TDATA_W = 40;

    // Q30 fractions: value range 0..2^30 needs 31 bits
    localparam int QB = 30;
    localparam int TW = QB + 1;
    localparam logic [TW-1:0] QONE = TW'(1) << QB;

    // floor(2^38 / 90): scales a degree magnitude to a Q30 fraction of 90 degrees
    localparam logic [31:0] RECIP90  = 32'd3054198966;
    localparam int          RECIP_SH = 8;

    // Taylor coefficients of sin(pi/2 * t) in Q30, highest order first
    localparam int NCOEF = 7;
    localparam logic [TW-1:0] SIN_COEF [NCOEF] = '{
        31'd61, 31'd3864, 31'd172272, 31'd5026995,
        31'd85569306, 31'd693598668, 31'd1686629713
    };

    // Trig lanes carried side by side
    localparam int LANES = 4;
    localparam int LN_SA = 0;   // sin of half longitude
    localparam int LN_CA = 1;   // cos of half longitude
    localparam int LN_SL = 2;   // sin of latitude
    localparam int LN_CL = 3;   // cos of latitude

    // Square root: one result bit per stage over a 62-bit radicand
    localparam int SQ_STEPS = 31;
    localparam int SQ_NW    = 62;
    localparam int SQ_RW    = 63;

    typedef logic [LANES-1:0][TW-1:0] lanes_t;

    typedef struct packed {
        logic lon_neg;
        logic lat_neg;
    } sign_t;

endpackage

>>> hdl/hap_front.sv
// Input conditioning: clamp, sign/magnitude split and conversion of both angles
// to Q30 fractions of a right angle (three stages). Depends on hap_pkg.
module hap_front #(
    parameter int FRAC_BITS = hap_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [hap_pkg::LON_W-1:0]    longitude,
    input  logic signed [hap_pkg::LAT_W-1:0]    latitude,
    output logic                                out_valid,
    input  logic                                out_ready,
    output hap_pkg::lanes_t                     targ,
    output hap_pkg::sign_t                      out_sign
);
    import hap_pkg::*;

    localparam int LON_LIM  = 180 << FRAC_BITS;
    localparam int LAT_LIM  = 90 << FRAC_BITS;
    localparam int LON_HALF = LON_LIM / 2;
    localparam int LAT_HALF = LAT_LIM / 2;
    localparam logic signed [31:0] LON_LIM_S = 32'(LON_LIM);
    localparam logic signed [31:0] LAT_LIM_S = 32'(LAT_LIM);
    localparam int SH_LON = RECIP_SH + 1 + FRAC_BITS;
    localparam int SH_LAT = RECIP_SH + FRAC_BITS;
    localparam int PW_LON = LON_W + 32;
    localparam int PW_LAT = LAT_W + 32;
    localparam int CW_LON = $clog2(LON_LIM + 1) + TW + 1;
    localparam int CW_LAT = $clog2(LAT_LIM + 1) + TW + 1;

    logic [2:0] v_reg;
    logic [2:0] en;

    logic [LON_W-1:0]  mlon0_reg, mlon0_next, mlon1_reg;
    logic [LAT_W-1:0]  mlat0_reg, mlat0_next, mlat1_reg;
    logic [PW_LON-1:0] plon_reg, plon_next;
    logic [PW_LAT-1:0] plat_reg, plat_next;
    logic [TW-1:0]     elon_reg, elon_next, elat_reg, elat_next;
    sign_t             sg0_reg, sg0_next, sg1_reg, sg2_reg;
    lanes_t            targ_reg, targ_next;

    logic signed [31:0] lon_ext, lon_c, lon_abs;
    logic signed [31:0] lat_ext, lat_c, lat_abs;
    logic [PW_LON:0]    elon_sum;
    logic [PW_LAT:0]    elat_sum;
    logic [CW_LON-1:0]  lhs_lon, rhs_lon;
    logic [CW_LAT-1:0]  lhs_lat, rhs_lat;
    logic [TW-1:0]      tlon_r, tlat_r, tlon, tlat;

    // Advance a stage when it is empty or the one after it moves
    always_comb
    begin
        en[2]    = !v_reg[2] || out_ready;
        en[1]    = !v_reg[1] || en[2];
        en[0]    = !v_reg[0] || en[1];
        in_ready = en[0];
    end

    // Stage 0: clamp, split sign, scale by the reciprocal of the full angle
    always_comb
    begin
        lon_ext = 32'(longitude);
        lat_ext = 32'(latitude);
        lon_c = (lon_ext > LON_LIM_S) ? LON_LIM_S :
                (lon_ext < -LON_LIM_S) ? -LON_LIM_S : lon_ext;
        lat_c = (lat_ext > LAT_LIM_S) ? LAT_LIM_S :
                (lat_ext < -LAT_LIM_S) ? -LAT_LIM_S : lat_ext;
        sg0_next.lon_neg = lon_c[31];
        sg0_next.lat_neg = lat_c[31];
        lon_abs    = lon_c[31] ? -lon_c : lon_c;
        lat_abs    = lat_c[31] ? -lat_c : lat_c;
        mlon0_next = lon_abs[LON_W-1:0];
        mlat0_next = lat_abs[LAT_W-1:0];
        plon_next  = PW_LON'(mlon0_next) * PW_LON'(RECIP90);
        plat_next  = PW_LAT'(mlat0_next) * PW_LAT'(RECIP90);
    end

    // Stage 1: rounded estimate, at most one below the true quotient
    always_comb
    begin
        elon_sum  = (PW_LON + 1)'(plon_reg) + ((PW_LON + 1)'(1) << (SH_LON - 1));
        elat_sum  = (PW_LAT + 1)'(plat_reg) + ((PW_LAT + 1)'(1) << (SH_LAT - 1));
        elon_next = TW'(elon_sum >> SH_LON);
        elat_next = TW'(elat_sum >> SH_LAT);
    end

    // Stage 2: bump the estimate where the remainder still covers a divisor
    always_comb
    begin
        lhs_lon = (CW_LON'(mlon1_reg) << QB) + CW_LON'(LON_HALF);
        rhs_lon = CW_LON'(LON_LIM) * (CW_LON'(elon_reg) + CW_LON'(1));
        lhs_lat = (CW_LAT'(mlat1_reg) << QB) + CW_LAT'(LAT_HALF);
        rhs_lat = CW_LAT'(LAT_LIM) * (CW_LAT'(elat_reg) + CW_LAT'(1));
        tlon_r  = (lhs_lon >= rhs_lon) ? elon_reg + TW'(1) : elon_reg;
        tlat_r  = (lhs_lat >= rhs_lat) ? elat_reg + TW'(1) : elat_reg;
        tlon    = (tlon_r > QONE) ? QONE : tlon_r;
        tlat    = (tlat_r > QONE) ? QONE : tlat_r;
        targ_next[LN_SA] = tlon;
        targ_next[LN_CA] = QONE - tlon;
        targ_next[LN_SL] = tlat;
        targ_next[LN_CL] = QONE - tlat;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0]) v_reg[0] <= in_valid;
            if (en[1]) v_reg[1] <= v_reg[0];
            if (en[2]) v_reg[2] <= v_reg[1];
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            mlon0_reg <= mlon0_next;
            mlat0_reg <= mlat0_next;
            plon_reg  <= plon_next;
            plat_reg  <= plat_next;
            sg0_reg   <= sg0_next;
        end
        if (en[1])
        begin
            mlon1_reg <= mlon0_reg;
            mlat1_reg <= mlat0_reg;
            elon_reg  <= elon_next;
            elat_reg  <= elat_next;
            sg1_reg   <= sg0_reg;
        end
        if (en[2])
        begin
            targ_reg <= targ_next;
            sg2_reg  <= sg1_reg;
        end
    end

    assign out_valid = v_reg[2];
    assign targ      = targ_reg;
    assign out_sign  = sg2_reg;

endmodule

>>> hdl/hap_sin.sv
// Four-lane sine pipeline: odd Taylor polynomial in Horner form, one
// multiply per stage, eight stages. Depends on hap_pkg.
module hap_sin (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  hap_pkg::lanes_t arg,
    input  hap_pkg::sign_t  in_sign,
    output logic            out_valid,
    input  logic            out_ready,
    output hap_pkg::lanes_t val,
    output hap_pkg::sign_t  out_sign
);
    import hap_pkg::*;

    localparam int NST = NCOEF + 1;

    logic [NST-1:0] v_reg, v_next, en;
    lanes_t t_reg [NST];
    lanes_t t_next [NST];
    lanes_t t2_reg [NST];
    lanes_t t2_next [NST];
    lanes_t p_reg [NST];
    lanes_t p_next [NST];
    sign_t  sg_reg [NST];
    sign_t  sg_next [NST];
    logic [2*TW-1:0] mul [NST][LANES];
    logic [TW:0]     s_full [LANES];

    // Advance a stage when it is empty or the one after it moves
    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || out_ready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
        in_ready = en[0];
    end

    // Square the argument, then one Horner step per stage, then scale by t
    always_comb
    begin
        v_next[0]  = in_valid;
        t_next[0]  = arg;
        sg_next[0] = in_sign;
        for (int l = 0; l < LANES; l++)
        begin
            mul[0][l]     = (2*TW)'(arg[l]) * (2*TW)'(arg[l]);
            t2_next[0][l] = TW'(mul[0][l] >> QB);
            p_next[0][l]  = SIN_COEF[0];
        end
        for (int k = 1; k < NST; k++)
        begin
            v_next[k]  = v_reg[k-1];
            t_next[k]  = t_reg[k-1];
            t2_next[k] = t2_reg[k-1];
            sg_next[k] = sg_reg[k-1];
            for (int l = 0; l < LANES; l++)
            begin
                if (k < NST - 1)
                begin
                    mul[k][l]    = (2*TW)'(p_reg[k-1][l]) * (2*TW)'(t2_reg[k-1][l]);
                    p_next[k][l] = SIN_COEF[k] - TW'(mul[k][l] >> QB);
                end
                else
                begin
                    mul[k][l]    = (2*TW)'(p_reg[k-1][l]) * (2*TW)'(t_reg[k-1][l]);
                    p_next[k][l] = '0;
                end
            end
        end
        // Limit the final product to one
        for (int l = 0; l < LANES; l++)
        begin
            s_full[l] = (TW + 1)'(mul[NST-1][l] >> QB);
            p_next[NST-1][l] = (s_full[l] > (TW + 1)'(QONE)) ? QONE : s_full[l][TW-1:0];
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NST; k++)
            begin
                if (en[k]) v_reg[k] <= v_next[k];
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NST; k++)
        begin
            if (en[k])
            begin
                t_reg[k]  <= t_next[k];
                t2_reg[k] <= t2_next[k];
                p_reg[k]  <= p_next[k];
                sg_reg[k] <= sg_next[k];
            end
        end
    end

    assign out_valid = v_reg[NST-1];
    assign val       = p_reg[NST-1];
    assign out_sign  = sg_reg[NST-1];

endmodule

>>> hdl/hap_root.sv
// Denominator: forms 1 + cos(lat)*cos(lon/2) and the numerator product, then
// takes the Q30 square root one result bit per stage (32 stages). Depends on hap_pkg.
module hap_root (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  hap_pkg::lanes_t          trig,
    input  hap_pkg::sign_t           in_sign,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [hap_pkg::TW-1:0]   root,
    output logic [hap_pkg::TW-1:0]   num,
    output logic [hap_pkg::TW-1:0]   sin_lat,
    output hap_pkg::sign_t           out_sign
);
    import hap_pkg::*;

    localparam int NST = SQ_STEPS + 1;

    logic [NST-1:0]   v_reg, v_next, en;
    logic [SQ_NW-1:0] n_reg [NST];
    logic [SQ_NW-1:0] n_next [NST];
    logic [SQ_RW-1:0] r_reg [NST];
    logic [SQ_RW-1:0] r_next [NST];
    logic [TW-1:0]    num_reg [NST];
    logic [TW-1:0]    num_next [NST];
    logic [TW-1:0]    sl_reg [NST];
    logic [TW-1:0]    sl_next [NST];
    sign_t            sg_reg [NST];
    sign_t            sg_next [NST];
    logic [SQ_RW-1:0] sq_bit [NST];
    logic [SQ_RW-1:0] sq_sum [NST];
    logic [2*TW-1:0]  mul_cc, mul_cs;
    logic [TW:0]      d_val;

    // Advance a stage when it is empty or the one after it moves
    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || out_ready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
        in_ready = en[0];
    end

    always_comb
    begin
        // Stage 0: products of the trig lanes, radicand D scaled to Q60
        mul_cc      = (2*TW)'(trig[LN_CL]) * (2*TW)'(trig[LN_CA]);
        mul_cs      = (2*TW)'(trig[LN_CL]) * (2*TW)'(trig[LN_SA]);
        d_val       = (TW + 1)'(QONE) + (TW + 1)'(mul_cc >> QB);
        v_next[0]   = in_valid;
        n_next[0]   = SQ_NW'(d_val) << QB;
        r_next[0]   = '0;
        num_next[0] = TW'(mul_cs >> QB);
        sl_next[0]  = trig[LN_SL];
        sg_next[0]  = in_sign;
        sq_bit[0]   = '0;
        sq_sum[0]   = '0;
        // Stages 1..: restoring square root, bit weight 4^(steps-k)
        for (int k = 1; k < NST; k++)
        begin
            v_next[k]   = v_reg[k-1];
            num_next[k] = num_reg[k-1];
            sl_next[k]  = sl_reg[k-1];
            sg_next[k]  = sg_reg[k-1];
            sq_bit[k]   = SQ_RW'(1) << (2 * (SQ_STEPS - k));
            sq_sum[k]   = r_reg[k-1] + sq_bit[k];
            if (SQ_RW'(n_reg[k-1]) >= sq_sum[k])
            begin
                n_next[k] = n_reg[k-1] - SQ_NW'(sq_sum[k]);
                r_next[k] = (r_reg[k-1] >> 1) + sq_bit[k];
            end
            else
            begin
                n_next[k] = n_reg[k-1];
                r_next[k] = r_reg[k-1] >> 1;
            end
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NST; k++)
            begin
                if (en[k]) v_reg[k] <= v_next[k];
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NST; k++)
        begin
            if (en[k])
            begin
                n_reg[k]   <= n_next[k];
                r_reg[k]   <= r_next[k];
                num_reg[k] <= num_next[k];
                sl_reg[k]  <= sl_next[k];
                sg_reg[k]  <= sg_next[k];
            end
        end
    end

    assign out_valid = v_reg[NST-1];
    assign root      = r_reg[NST-1][TW-1:0];
    assign num       = num_reg[NST-1];
    assign sin_lat   = sl_reg[NST-1];
    assign out_sign  = sg_reg[NST-1];

endmodule

>>> hdl/hap_div.sv
// Output scaling: rounded division of both numerators by the root, one quotient
// bit per stage, then saturation and sign. FRAC_BITS + 10 stages. Depends on hap_pkg.
module hap_div #(
    parameter int FRAC_BITS = hap_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [hap_pkg::TW-1:0]             root,
    input  logic [hap_pkg::TW-1:0]             num,
    input  logic [hap_pkg::TW-1:0]             sin_lat,
    input  hap_pkg::sign_t                     in_sign,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [hap_pkg::X_W-1:0]     plot_x,
    output logic signed [hap_pkg::Y_W-1:0]     plot_y
);
    import hap_pkg::*;

    localparam int LX   = 180 << FRAC_BITS;
    localparam int LY   = 90 << FRAC_BITS;
    localparam int QD   = FRAC_BITS + 8;
    localparam int NW   = TW + QD + 1;
    localparam int NDS  = QD + 1;
    localparam int NST  = QD + 2;
    localparam int XMAX = (1 << (X_W - 1)) - 1;
    localparam int YMAX = (1 << (Y_W - 1)) - 1;
    localparam logic [31:0] XLIM = 32'((LX > XMAX) ? XMAX : LX);
    localparam logic [31:0] YLIM = 32'((LY > YMAX) ? YMAX : LY);

    logic [NST-1:0] v_reg, v_next, en;
    logic [TW-1:0]  d_reg [NDS];
    logic [TW-1:0]  d_next [NDS];
    logic [NW-1:0]  rx_reg [NDS];
    logic [NW-1:0]  rx_next [NDS];
    logic [NW-1:0]  ry_reg [NDS];
    logic [NW-1:0]  ry_next [NDS];
    logic [QD-1:0]  qx_reg [NDS];
    logic [QD-1:0]  qx_next [NDS];
    logic [QD-1:0]  qy_reg [NDS];
    logic [QD-1:0]  qy_next [NDS];
    sign_t          sg_reg [NDS];
    sign_t          sg_next [NDS];
    logic [NW-1:0]  dsh [NDS];
    logic [TW-1:0]  r_lim;
    logic [31:0]    qx32, qy32, magx, magy;
    logic signed [X_W-1:0] x_reg, x_next;
    logic signed [Y_W-1:0] y_reg, y_next;

    // Advance a stage when it is empty or the one after it moves
    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || out_ready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
        in_ready = en[0];
    end

    always_comb
    begin
        // Stage 0: dividends with half the divisor added for rounding
        r_lim      = (root < QONE) ? QONE : root;
        v_next[0]  = in_valid;
        d_next[0]  = r_lim;
        rx_next[0] = NW'(num) * NW'(LX) + NW'(r_lim >> 1);
        ry_next[0] = NW'(sin_lat) * NW'(LY) + NW'(r_lim >> 1);
        qx_next[0] = '0;
        qy_next[0] = '0;
        sg_next[0] = in_sign;
        dsh[0]     = '0;
        // Stages 1..QD: restoring division, most significant bit first
        for (int k = 1; k < NDS; k++)
        begin
            v_next[k]  = v_reg[k-1];
            d_next[k]  = d_reg[k-1];
            sg_next[k] = sg_reg[k-1];
            dsh[k]     = NW'(d_reg[k-1]) << (QD - k);
            rx_next[k] = rx_reg[k-1];
            ry_next[k] = ry_reg[k-1];
            qx_next[k] = qx_reg[k-1];
            qy_next[k] = qy_reg[k-1];
            if (rx_reg[k-1] >= dsh[k])
            begin
                rx_next[k]          = rx_reg[k-1] - dsh[k];
                qx_next[k][QD - k]  = 1'b1;
            end
            if (ry_reg[k-1] >= dsh[k])
            begin
                ry_next[k]          = ry_reg[k-1] - dsh[k];
                qy_next[k][QD - k]  = 1'b1;
            end
        end
        // Last stage: saturate to range and field, then apply the sign
        v_next[NST-1] = v_reg[NDS-1];
        qx32   = 32'(qx_reg[NDS-1]);
        qy32   = 32'(qy_reg[NDS-1]);
        magx   = (qx32 > XLIM) ? XLIM : qx32;
        magy   = (qy32 > YLIM) ? YLIM : qy32;
        x_next = sg_reg[NDS-1].lon_neg ? -X_W'(magx) : X_W'(magx);
        y_next = sg_reg[NDS-1].lat_neg ? -Y_W'(magy) : Y_W'(magy);
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NST; k++)
            begin
                if (en[k]) v_reg[k] <= v_next[k];
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NDS; k++)
        begin
            if (en[k])
            begin
                d_reg[k]  <= d_next[k];
                rx_reg[k] <= rx_next[k];
                ry_reg[k] <= ry_next[k];
                qx_reg[k] <= qx_next[k];
                qy_reg[k] <= qy_next[k];
                sg_reg[k] <= sg_next[k];
            end
        end
        if (en[NST-1])
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    assign out_valid = v_reg[NST-1];
    assign plot_x    = x_reg;
    assign plot_y    = y_reg;

endmodule

>>> hdl/hammer_aitoff_projection.sv
// Hammer-Aitoff equal-area projection, top level.
// Uses hap_pkg, hap_front, hap_sin, hap_root and hap_div.
//
// Usage:
//   Slave channel s_axis_* takes one sky point per beat: longitude and
//   latitude in signed fixed-point degrees with FRAC_BITS fraction bits.
//   Out-of-range angles are clamped to +-180 and +-90 degrees.
//   Master channel m_axis_* returns one beat per point, in order: the plot
//   position in the same format.
//   Most stages lie in the 31-stage square root and in the divider,
//   which yields one quotient bit per stage.
//   Throughput is one point per cycle; every stage has its own valid bit,
//   so a new beat enters each cycle while any stage is free.
//   When the receiver stalls, the result is held on m_axis_tdata and the
//   pipeline fills from the back; s_axis_tready drops only once every
//   stage holds a beat. Nothing is dropped or repeated.
//   Reset clears all valid bits; no memory needs clearing.
module hammer_aitoff_projection #(
    parameter int FRAC_BITS = hap_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // longitude [16:0], latitude [32:17], zero [39:33]
    input  logic [hap_pkg::TDATA_W-1:0]    s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // plot_x [16:0], plot_y [32:17], zero [39:33]
    output logic [hap_pkg::TDATA_W-1:0]    m_axis_tdata
);
    import hap_pkg::*;

    logic signed [LON_W-1:0] longitude;
    logic signed [LAT_W-1:0] latitude;
    logic signed [X_W-1:0]   plot_x;
    logic signed [Y_W-1:0]   plot_y;

    logic   fr_valid, fr_ready, sn_valid, sn_ready, rt_valid, rt_ready;
    lanes_t fr_targ, sn_val;
    sign_t  fr_sign, sn_sign, rt_sign;
    logic [TW-1:0] rt_root, rt_num, rt_sl;

    // Unpack the input beat
    assign longitude = s_axis_tdata[LON_W-1:0];
    assign latitude  = s_axis_tdata[LON_W+LAT_W-1:LON_W];

    hap_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .longitude (longitude),
        .latitude  (latitude),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .targ      (fr_targ),
        .out_sign  (fr_sign)
    );

    hap_sin u_sin (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .arg       (fr_targ),
        .in_sign   (fr_sign),
        .out_valid (sn_valid),
        .out_ready (sn_ready),
        .val       (sn_val),
        .out_sign  (sn_sign)
    );

    hap_root u_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sn_valid),
        .in_ready  (sn_ready),
        .trig      (sn_val),
        .in_sign   (sn_sign),
        .out_valid (rt_valid),
        .out_ready (rt_ready),
        .root      (rt_root),
        .num       (rt_num),
        .sin_lat   (rt_sl),
        .out_sign  (rt_sign)
    );

    hap_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rt_valid),
        .in_ready  (rt_ready),
        .root      (rt_root),
        .num       (rt_num),
        .sin_lat   (rt_sl),
        .in_sign   (rt_sign),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .plot_x    (plot_x),
        .plot_y    (plot_y)
    );

    // Pack the output beat
    assign m_axis_tdata = {(TDATA_W - X_W - Y_W)'(0), plot_y, plot_x};

endmodule

>>> hdl/hap_checker.sv
// Port-level checks for hammer_aitoff_projection, attached by bind.
// Depends on hap_pkg.
module hap_checker #(
    parameter int FRAC_BITS = hap_pkg::FRAC_BITS_DEF
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [hap_pkg::TDATA_W-1:0] m_axis_tdata
);
    import hap_pkg::*;

    localparam int LX   = 180 << FRAC_BITS;
    localparam int LY   = 90 << FRAC_BITS;
    localparam int XMAX = (1 << (X_W - 1)) - 1;
    localparam int YMAX = (1 << (Y_W - 1)) - 1;
    localparam logic signed [31:0] XLIM = 32'((LX > XMAX) ? XMAX : LX);
    localparam logic signed [31:0] YLIM = 32'((LY > YMAX) ? YMAX : LY);

    logic signed [31:0] x_val, y_val;

    assign x_val = 32'($signed(m_axis_tdata[X_W-1:0]));
    assign y_val = 32'($signed(m_axis_tdata[X_W+Y_W-1:X_W]));

    // A stalled result beat stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat withdrawn under stall");

    // A stalled result beat keeps its data
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result data changed under stall");

    // A ready receiver lets the whole pipeline advance, so the input is ready too
    a_ready_pass: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while receiver ready");

    // Horizontal position stays within the projection range
    a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (x_val <= XLIM) && (x_val >= -XLIM))
        else $error("plot_x outside range");

    // Vertical position stays within range and the pad bits are zero
    a_y_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (y_val <= YLIM) && (y_val >= -YLIM) &&
                          (m_axis_tdata[TDATA_W-1:X_W+Y_W] == '0))
        else $error("plot_y outside range or pad bits set");

endmodule

bind hammer_aitoff_projection hap_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_hap_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> test/hammer_aitoff_projection_tb.sv
// Testbench for the Hammer-Aitoff projection pipeline: random and directed sky points
// are streamed in, and each plot beat is checked against an integer predictor held here.
// Depends on hap_pkg and hammer_aitoff_projection.
module hammer_aitoff_projection_tb;
    import hap_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int LON_LIM = 180 << FB;
    localparam int LAT_LIM = 90 << FB;
    localparam int LATENCY = 53 + FB;
    localparam longint unsigned ONE_Q = 64'd1 << 30;

    typedef struct packed {
        logic signed [X_W-1:0] px;
        logic signed [Y_W-1:0] py;
    } plot_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;

    plot_t plot_queue[$];
    int n_sent;
    int n_checked;
    int n_errors;
    bit rx_hold;
    bit rx_busy_gaps;

    hammer_aitoff_projection i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Q30 sine of 90*t degrees by odd polynomial, Horner form
    function automatic longint unsigned sine_q30(longint unsigned t);
        longint unsigned coef[7];
        longint unsigned t2;
        longint unsigned p;
        longint unsigned s;
        coef = '{61, 3864, 172272, 5026995, 85569306, 693598668, 1686629713};
        if (t > ONE_Q)
            t = ONE_Q;
        t2 = (t * t) >> 30;
        p = coef[0];
        for (int k = 1; k < 7; k++)
            p = coef[k] - ((p * t2) >> 30);
        s = (p * t) >> 30;
        return (s > ONE_Q) ? ONE_Q : s;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned angle_frac(longint unsigned m, longint unsigned full);
        longint unsigned t;
        t = ((m << 30) + full / 2) / full;
        return (t > ONE_Q) ? ONE_Q : t;
    endfunction

    // Plot position of one sky point
    function automatic plot_t project_point(logic signed [LON_W-1:0] lon_in,
                                            logic signed [LAT_W-1:0] lat_in);
        longint lon;
        longint lat;
        bit lon_neg;
        bit lat_neg;
        longint unsigned ta, tl, sa, ca, sl, cl, d, r, num, xm, ym;
        plot_t res;
        lon = longint'(lon_in);
        lat = longint'(lat_in);
        if (lon > LON_LIM) lon = LON_LIM;
        if (lon < -LON_LIM) lon = -LON_LIM;
        if (lat > LAT_LIM) lat = LAT_LIM;
        if (lat < -LAT_LIM) lat = -LAT_LIM;
        lon_neg = lon < 0;
        lat_neg = lat < 0;
        ta = angle_frac(lon_neg ? -lon : lon, LON_LIM);
        tl = angle_frac(lat_neg ? -lat : lat, LAT_LIM);
        sa = sine_q30(ta);
        ca = sine_q30(ONE_Q - ta);
        sl = sine_q30(tl);
        cl = sine_q30(ONE_Q - tl);
        d = ONE_Q + ((cl * ca) >> 30);
        r = root_floor(d << 30);
        if (r < ONE_Q)
            r = ONE_Q;
        num = (cl * sa) >> 30;
        xm = (num * LON_LIM + r / 2) / r;
        ym = (sl * LAT_LIM + r / 2) / r;
        if (xm > LON_LIM) xm = LON_LIM;
        if (ym > LAT_LIM) ym = LAT_LIM;
        res.px = X_W'(lon_neg ? -longint'(xm) : longint'(xm));
        res.py = Y_W'(lat_neg ? -longint'(ym) : longint'(ym));
        return res;
    endfunction

    // Offer one point after a random gap and hold until accepted
    task automatic send_point(logic [LON_W-1:0] lon, logic [LAT_W-1:0] lat, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 18)) : 0);
        if (gap > 0)
            s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, lat, lon};
        plot_queue.push_back(project_point(lon, lat));
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        n_sent++;
        @(negedge clk);
    endtask

    // Field extremes, poles, seams, clamping of out-of-range angles
    task automatic test_directed();
        int lons[9];
        int lats[7];
        lons = '{0, 1, -1, LON_LIM, -LON_LIM, 65535, -65536, 23040, -23040};
        lats = '{0, LAT_LIM, -LAT_LIM, 32767, -32768, 1, -1};
        foreach (lats[j])
            send_point(LON_W'(lons[j]), LAT_W'(lats[j]));
        foreach (lons[i])
            send_point(LON_W'(lons[i]), LAT_W'((i % 2) ? 11520 : -11520));
        send_point(LON_W'(-65536), LAT_W'(-32768));
        send_point(LON_W'(65535), LAT_W'(32767));
    endtask

    // Mostly in-range points, some beyond the clamp limits
    task automatic test_random(int count);
        logic [LON_W-1:0] lon;
        logic [LAT_W-1:0] lat;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                lon = LON_W'($urandom);
                lat = LAT_W'($urandom);
            end
            else
            begin
                lon = LON_W'($urandom_range(0, 2 * LON_LIM) - LON_LIM);
                lat = LAT_W'($urandom_range(0, 2 * LAT_LIM) - LAT_LIM);
            end
            send_point(lon, lat);
        end
    endtask

    // Stall the receiver long enough for the pipeline to fill and back-pressure
    task automatic test_backpressure();
        rx_hold = 1'b1;
        for (int i = 0; i < LATENCY + 40; i++)
            send_point(LON_W'($urandom_range(0, 2 * LON_LIM) - LON_LIM),
                       LAT_W'($urandom_range(0, 2 * LAT_LIM) - LAT_LIM), 1);
        rx_hold = 1'b0;
    endtask

    // Back-to-back beats with the receiver always ready
    task automatic test_streaming(int count);
        rx_busy_gaps = 1'b0;
        for (int i = 0; i < count; i++)
            send_point(LON_W'($urandom), LAT_W'($urandom), 1);
        rx_busy_gaps = 1'b1;
    endtask

    // Receiver process: counted long hold-off, random short gaps, or always ready
    initial
    begin
        m_axis_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold)
            begin
                m_axis_tready <= 1'b0;
                repeat (LATENCY + 60) @(negedge clk);
                m_axis_tready <= 1'b1;
                wait (!rx_hold);
            end
            else if (rx_busy_gaps && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Compare each plot beat with the oldest prediction
    always @(posedge clk)
    begin
        plot_t got;
        plot_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.px = m_axis_tdata[16:0];
            got.py = m_axis_tdata[32:17];
            if (plot_queue.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected beat: x=%0d y=%0d", got.px, got.py);
            end
            else
            begin
                want = plot_queue.pop_front();
                n_checked++;
                if (got !== want || m_axis_tdata[39:33] !== 7'd0)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch at beat %0d: x exp %0d got %0d, y exp %0d got %0d",
                                 n_checked, want.px, got.px, want.py, got.py);
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int guard;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        n_sent = 0;
        n_checked = 0;
        n_errors = 0;
        rx_hold = 1'b0;
        rx_busy_gaps = 1'b1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random(700);
        test_backpressure();
        test_streaming(200);
        test_random(500);
        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (plot_queue.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY + 10) @(posedge clk);
        $display("Projected %0d sky points incl. poles, seams, clamping and a full stall;",
                 n_sent);
        $display("%0d plot beats checked, %0d mismatches.", n_checked, n_errors);
        if (n_errors == 0 && plot_queue.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
